@@ rtl/mbd_pkg.sv @@
package mbd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned DELIM_BYTES = 32;
  localparam int unsigned DELIM_BITS  = DELIM_BYTES * BYTE_W;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned PART_W      = 16;
  localparam int unsigned APB_AW      = 6;
  localparam int unsigned APB_DW      = 64;

  localparam logic [LEN_W-1:0]  LEN_MIN   = 6'd3;
  localparam logic [LEN_W-1:0]  LEN_RESET = 6'd3;
  localparam logic [PART_W-1:0] PART_MAX  = 16'hFFFF;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  typedef logic [BYTE_W-1:0] byte_t;

  // events handed from the window to the part tracker
  typedef enum logic [1:0] {
    EV_BYTE,
    EV_HIT,
    EV_END
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e kind;
    byte_t    data;
  } ev_t;

  typedef struct packed {
    logic              stream_end;
    logic              part_end;
    logic [PART_W-1:0] part_number;
    logic              in_body;
    logic              byte_valid;
    byte_t             out_byte;
  } res_t;

endpackage

@@ rtl/mbd_cell.sv @@
module mbd_cell import mbd_pkg::*; (
  input  logic  clk_i,
  input  logic  shift_i,
  input  byte_t byte_i,
  input  byte_t exp_i,
  input  logic  care_i,
  output byte_t byte_o,
  output logic  eq_o
);

  byte_t byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  // compare is on the incoming byte, so the hit is known in the shift cycle
  assign eq_o   = !care_i || (byte_i == exp_i);
  assign byte_o = byte_q;

endmodule

@@ rtl/mbd_window.sv @@
module mbd_window import mbd_pkg::*; #(
  parameter int unsigned NCELL = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  byte_t                 in_byte_i,
  input  logic                  in_last_i,
  input  logic [LEN_W-1:0]      len_i,
  input  logic [DELIM_BITS-1:0] delim_i,
  input  logic                  ev_pop_i,
  output logic                  ev_valid_o,
  output ev_t                   ev_o
);

  localparam int unsigned FW = $clog2(NCELL + 1);
  localparam int unsigned IW = $clog2(NCELL);

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_e;

  state_e           st_q, st_d;
  logic [FW-1:0]    fill_q, fill_d;
  logic             ev_valid_q, ev_valid_d;
  ev_t              ev_q, ev_d;

  logic [FW-1:0]         l;
  logic [FW-1:0]         fill_adj;
  logic [FW-1:0]         fill_new;
  logic                  full;
  logic                  hit;
  logic                  accept;
  logic                  ev_free;
  logic [LEN_W-1:0]      sh;
  logic [DELIM_BITS-1:0] rev_vec;
  logic [DELIM_BITS-1:0] exp_vec;
  logic [NCELL-1:0]      eq;
  logic [NCELL-1:0]      care;
  byte_t                 line_in   [NCELL];
  byte_t                 cell_byte [NCELL];

  assign l = len_i[FW-1:0];

  // cell k (age k, newest at 0) compares against delimiter byte l-1-k:
  // reverse the delimiter bytes and shift right by 32-l bytes
  for (genvar j = 0; j < DELIM_BYTES; j++) begin : g_rev
    assign rev_vec[BYTE_W*j +: BYTE_W] = delim_i[BYTE_W*(DELIM_BYTES-1-j) +: BYTE_W];
  end

  assign sh      = LEN_W'(DELIM_BYTES) - len_i;
  assign exp_vec = rev_vec >> {sh, 3'b000};

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign line_in[k] = in_byte_i;
    end else begin : g_link
      assign line_in[k] = cell_byte[k-1];
    end
    assign care[k] = LEN_W'(k) < len_i;

    mbd_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (accept),
      .byte_i  (line_in[k]),
      .exp_i   (exp_vec[BYTE_W*k +: BYTE_W]),
      .care_i  (care[k]),
      .byte_o  (cell_byte[k]),
      .eq_o    (eq[k])
    );
  end

  assign ev_free    = !ev_valid_q || ev_pop_i;
  assign in_ready_o = (st_q == ST_RUN) && ev_free;
  assign accept     = in_valid_i && in_ready_o;

  // a shorter length drops the oldest pending bytes
  assign fill_adj = (fill_q >= l) ? l - 1'b1 : fill_q;
  assign fill_new = fill_adj + 1'b1;
  assign full     = fill_new == l;
  assign hit      = full && (&eq);

  always_comb begin
    st_d       = st_q;
    fill_d     = fill_q;
    ev_valid_d = ev_valid_q && !ev_pop_i;
    ev_d       = ev_q;
    unique case (st_q)
      ST_RUN: begin
        if (accept) begin
          fill_d = fill_new;
          if (full) begin
            ev_valid_d = 1'b1;
            if (hit) begin
              fill_d     = '0;
              ev_d.kind  = EV_HIT;
              ev_d.data  = '0;
            end else begin
              fill_d     = l - 1'b1;
              ev_d.kind  = EV_BYTE;
              ev_d.data  = line_in[IW'(l - 1'b1)];
            end
          end
          if (in_last_i) begin
            st_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        // oldest pending byte first, then the end word
        if (ev_free) begin
          ev_valid_d = 1'b1;
          if (fill_q != '0) begin
            ev_d.kind = EV_BYTE;
            ev_d.data = cell_byte[IW'(fill_q - 1'b1)];
            fill_d    = fill_q - 1'b1;
          end else begin
            ev_d.kind = EV_END;
            ev_d.data = '0;
            st_d      = ST_RUN;
          end
        end
      end
      default: st_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_RUN;
      fill_q     <= '0;
      ev_valid_q <= 1'b0;
      ev_q       <= '0;
    end else begin
      st_q       <= st_d;
      fill_q     <= fill_d;
      ev_valid_q <= ev_valid_d;
      ev_q       <= ev_d;
    end
  end

  assign ev_valid_o = ev_valid_q;
  assign ev_o       = ev_q;

endmodule

@@ rtl/mbd_section.sv @@
module mbd_section import mbd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic ev_valid_i,
  input  ev_t  ev_i,
  input  logic out_ready_i,
  output logic ev_pop_o,
  output logic res_valid_o,
  output res_t res_o
);

  typedef enum logic [1:0] {
    CR_NONE,
    CR_SEEN_CR,
    CR_SEEN_CRLF,
    CR_SEEN_CRLFCR
  } crlf_e;

  logic              inside_q, inside_d;
  logic              body_q, body_d;
  crlf_e             crlf_q, crlf_d;
  logic [1:0]        trim_fill_q, trim_fill_d;
  logic [PART_W-1:0] part_q, part_d;
  byte_t             hold_q [2];
  byte_t             hold_d [2];

  assign ev_pop_o = ev_valid_i && out_ready_i;

  always_comb begin
    inside_d    = inside_q;
    body_d      = body_q;
    crlf_d      = crlf_q;
    trim_fill_d = trim_fill_q;
    part_d      = part_q;
    hold_d      = hold_q;
    res_valid_o = 1'b0;
    res_o             = '0;
    res_o.part_number = part_q;
    res_o.in_body     = body_q;
    unique case (ev_i.kind)
      EV_BYTE: begin
        if (inside_q && !body_q) begin
          res_valid_o      = 1'b1;
          res_o.out_byte   = ev_i.data;
          res_o.byte_valid = 1'b1;
          if (ev_i.data == CHAR_CR) begin
            crlf_d = (crlf_q == CR_SEEN_CRLF) ? CR_SEEN_CRLFCR : CR_SEEN_CR;
          end else if (ev_i.data == CHAR_LF && crlf_q == CR_SEEN_CR) begin
            crlf_d = CR_SEEN_CRLF;
          end else if (ev_i.data == CHAR_LF && crlf_q == CR_SEEN_CRLFCR) begin
            crlf_d = CR_NONE;
            body_d = 1'b1;
          end else begin
            crlf_d = CR_NONE;
          end
        end else if (inside_q) begin
          // body bytes lag two behind so the trailing CRLF can be dropped
          if (trim_fill_q != 2'd2) begin
            hold_d[trim_fill_q[0]] = ev_i.data;
            trim_fill_d            = trim_fill_q + 1'b1;
          end else begin
            res_valid_o      = 1'b1;
            res_o.out_byte   = hold_q[0];
            res_o.byte_valid = 1'b1;
            hold_d[0]        = hold_q[1];
            hold_d[1]        = ev_i.data;
          end
        end
      end
      EV_HIT: begin
        if (inside_q) begin
          res_valid_o    = 1'b1;
          res_o.part_end = 1'b1;
          if (part_q != PART_MAX) begin
            part_d = part_q + 1'b1;
          end
        end
        inside_d    = 1'b1;
        body_d      = 1'b0;
        crlf_d      = CR_NONE;
        trim_fill_d = '0;
      end
      EV_END: begin
        res_valid_o      = 1'b1;
        res_o.part_end   = inside_q;
        res_o.stream_end = 1'b1;
        inside_d    = 1'b0;
        body_d      = 1'b0;
        crlf_d      = CR_NONE;
        trim_fill_d = '0;
        part_d      = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q    <= 1'b0;
      body_q      <= 1'b0;
      crlf_q      <= CR_NONE;
      trim_fill_q <= '0;
      part_q      <= '0;
    end else if (ev_pop_o) begin
      inside_q    <= inside_d;
      body_q      <= body_d;
      crlf_q      <= crlf_d;
      trim_fill_q <= trim_fill_d;
      part_q      <= part_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_pop_o) begin
      hold_q <= hold_d;
    end
  end

endmodule

@@ rtl/multipart_body_deframer_core.sv @@
// A byte that yields a word passes the window event register, then the output word
// or skid register. Throughput: one input byte per cycle while the event register is
// free, set by the combinational window compare. A byte with tlast stalls s_axis while
// the window drains its pending bytes (fewer than the delimiter length) one a cycle,
// as the part tracker takes them, then the end word. Reset (rst_ni low, async): window,
// part state, output buffer cleared; delim_len returns to 3, delimiter words to zero.
module multipart_body_deframer_core import mbd_pkg::*; #(
  parameter int unsigned MAX_DELIM = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
  input  logic              s_axis_tlast,   // last_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // [7:0] out_byte, [23:8] part_number
  output logic [2:0]        m_axis_tuser,   // [0] byte_valid, [1] in_body, [2] part_end
  output logic              m_axis_tlast    // stream_end
);

  localparam int unsigned NCELL = (MAX_DELIM < DELIM_BYTES) ? MAX_DELIM : DELIM_BYTES;

  localparam logic [2:0] REG_LEN   = 3'd0;
  localparam logic [2:0] REG_WORD0 = 3'd1;
  localparam logic [2:0] REG_WORD1 = 3'd2;
  localparam logic [2:0] REG_WORD2 = 3'd3;
  localparam logic [2:0] REG_WORD3 = 3'd4;

  logic [LEN_W-1:0]  len_q;
  logic [APB_DW-1:0] word_q [4];
  logic [LEN_W-1:0]  len_eff;
  logic [2:0]        reg_idx;
  logic              cfg_wr;

  logic ev_valid;
  ev_t  ev;
  logic ev_pop;
  logic res_valid;
  res_t res;

  logic main_valid_q;
  res_t main_q;
  logic skid_valid_q;
  res_t skid_q;
  logic take;
  logic push;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_RESET;
      word_q <= '{default: '0};
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LEN:   len_q     <= pwdata[LEN_W-1:0];
        REG_WORD0: word_q[0] <= pwdata;
        REG_WORD1: word_q[1] <= pwdata;
        REG_WORD2: word_q[2] <= pwdata;
        REG_WORD3: word_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LEN:   prdata = {{(APB_DW-LEN_W){1'b0}}, len_q};
      REG_WORD0: prdata = word_q[0];
      REG_WORD1: prdata = word_q[1];
      REG_WORD2: prdata = word_q[2];
      REG_WORD3: prdata = word_q[3];
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    if (len_q < LEN_MIN) begin
      len_eff = LEN_MIN;
    end else if (len_q > LEN_W'(NCELL)) begin
      len_eff = LEN_W'(NCELL);
    end else begin
      len_eff = len_q;
    end
  end

  mbd_window #(
    .NCELL (NCELL)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .len_i      (len_eff),
    .delim_i    ({word_q[3], word_q[2], word_q[1], word_q[0]}),
    .ev_pop_i   (ev_pop),
    .ev_valid_o (ev_valid),
    .ev_o       (ev)
  );

  mbd_section u_section (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (ev_valid),
    .ev_i        (ev),
    .out_ready_i (!skid_valid_q),
    .ev_pop_o    (ev_pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output word register plus skid entry keeps tready off the input path
  assign take = main_valid_q && m_axis_tready;
  assign push = res_valid && ev_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q || take) begin
      main_valid_q <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || take) begin
      main_q <= skid_valid_q ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = main_valid_q;
  assign m_axis_tdata  = {main_q.part_number, main_q.out_byte};
  assign m_axis_tuser  = {main_q.part_end, main_q.in_body, main_q.byte_valid};
  assign m_axis_tlast  = main_q.stream_end;

endmodule
